// ===== src/i2ctrm_pkg.sv =====
// Shared types and constants for the I2C target register map.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package i2ctrm_pkg;

  localparam int BUFFER_BYTES_DEF = 12;
  localparam int BUF_INDEX_W      = 4;
  localparam int BYTE_W           = 8;
  localparam int CFG_ADDR_W       = 5;
  localparam int CFG_DATA_W       = 32;

  // Configuration register reset values
  localparam logic [BYTE_W-1:0] START_READ_CODE_RST = 8'd16;
  localparam logic [BYTE_W-1:0] RESET_CODE_RST      = 8'd32;
  localparam logic [BYTE_W-1:0] X_REG_ADDR_RST      = 8'd1;
  localparam logic [BYTE_W-1:0] Y_REG_ADDR_RST      = 8'd2;
  localparam logic [BYTE_W-1:0] G_REG_ADDR_RST      = 8'd3;
  localparam logic [BYTE_W-1:0] IDLE_POINTER_RST    = 8'd255;

  typedef enum logic [2:0] {
    CMD_RX     = 3'd0,
    CMD_READ   = 3'd1,
    CMD_FINISH = 3'd2,
    CMD_LOAD   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    REG_START_READ_CODE = 3'd0,
    REG_RESET_CODE      = 3'd1,
    REG_X_ADDR          = 3'd2,
    REG_Y_ADDR          = 3'd3,
    REG_G_ADDR          = 3'd4,
    REG_IDLE_POINTER    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    cmd_e                   cmd;
    logic [BYTE_W-1:0]      bus_byte;
    logic [BUF_INDEX_W-1:0] buf_index;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic [BYTE_W-1:0] x_enable;
    logic [BYTE_W-1:0] y_enable;
    logic [BYTE_W-1:0] g_enable;
    logic              updated;
    logic              reset_request;
  } out_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_read_code;
    logic [BYTE_W-1:0] reset_code;
    logic [BYTE_W-1:0] x_reg_addr;
    logic [BYTE_W-1:0] y_reg_addr;
    logic [BYTE_W-1:0] g_reg_addr;
    logic [BYTE_W-1:0] idle_pointer;
  } cfg_t;

endpackage

// ===== src/i2ctrm_regfile.sv =====
// APB-style configuration registers: codes and addresses of the register map.
// Depends on i2ctrm_pkg.
`timescale 1ns / 1ps

module i2ctrm_regfile (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2ctrm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [i2ctrm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [i2ctrm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                pready,
  output i2ctrm_pkg::cfg_t                    cfg
);
  import i2ctrm_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  logic        wr_en;
  reg_idx_e    idx;
  logic [BYTE_W-1:0] rd_byte;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    rd_byte = '0;
    unique case (idx)
      REG_START_READ_CODE: begin
        rd_byte = cfg_r.start_read_code;
        if (wr_en) cfg_nxt.start_read_code = pwdata[BYTE_W-1:0];
      end
      REG_RESET_CODE: begin
        rd_byte = cfg_r.reset_code;
        if (wr_en) cfg_nxt.reset_code = pwdata[BYTE_W-1:0];
      end
      REG_X_ADDR: begin
        rd_byte = cfg_r.x_reg_addr;
        if (wr_en) cfg_nxt.x_reg_addr = pwdata[BYTE_W-1:0];
      end
      REG_Y_ADDR: begin
        rd_byte = cfg_r.y_reg_addr;
        if (wr_en) cfg_nxt.y_reg_addr = pwdata[BYTE_W-1:0];
      end
      REG_G_ADDR: begin
        rd_byte = cfg_r.g_reg_addr;
        if (wr_en) cfg_nxt.g_reg_addr = pwdata[BYTE_W-1:0];
      end
      REG_IDLE_POINTER: begin
        rd_byte = cfg_r.idle_pointer;
        if (wr_en) cfg_nxt.idle_pointer = pwdata[BYTE_W-1:0];
      end
      default: rd_byte = '0;
    endcase
  end

  assign prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, rd_byte};
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_read_code <= START_READ_CODE_RST;
      cfg_r.reset_code      <= RESET_CODE_RST;
      cfg_r.x_reg_addr      <= X_REG_ADDR_RST;
      cfg_r.y_reg_addr      <= Y_REG_ADDR_RST;
      cfg_r.g_reg_addr      <= G_REG_ADDR_RST;
      cfg_r.idle_pointer    <= IDLE_POINTER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/i2ctrm_core.sv =====
// Event decode and register map state: pointer, enables, flags, transmit buffer.
// Depends on i2ctrm_pkg; configuration comes from i2ctrm_regfile.
`timescale 1ns / 1ps

module i2ctrm_core #(
  parameter int BUFFER_BYTES = i2ctrm_pkg::BUFFER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  i2ctrm_pkg::in_t   item,
  input  i2ctrm_pkg::cfg_t  cfg,
  output i2ctrm_pkg::out_t  res
);
  import i2ctrm_pkg::*;

  // buf_index stays below 2**BUF_INDEX_W, so window slots from there upward read zero
  localparam int TX_DEPTH = (BUFFER_BYTES < (1 << BUF_INDEX_W)) ?
                            BUFFER_BYTES : (1 << BUF_INDEX_W);

  logic [BYTE_W-1:0] ptr_r, ptr_nxt;
  logic              await_r, await_nxt;
  logic [BYTE_W-1:0] en_r   [3];
  logic [BYTE_W-1:0] en_nxt [3];
  logic [BYTE_W-1:0] tx_r   [TX_DEPTH];
  logic [BYTE_W-1:0] tx_nxt [TX_DEPTH];
  logic              upd_r, upd_nxt;
  logic              rreq_r, rreq_nxt;

  logic [BYTE_W-1:0] win_off;
  logic              in_win;
  logic [BYTE_W-1:0] tx_rd;
  logic [BYTE_W-1:0] rd;

  assign win_off = ptr_r - cfg.start_read_code;
  assign in_win  = (ptr_r >= cfg.start_read_code) &&
                   (win_off < BYTE_W'(BUFFER_BYTES));

  always_comb begin
    tx_rd = '0;
    for (int i = 0; i < TX_DEPTH; i++) begin
      if (win_off == BYTE_W'(i)) tx_rd = tx_r[i];
    end
  end

  always_comb begin
    ptr_nxt  = ptr_r;
    await_nxt = await_r;
    en_nxt   = en_r;
    tx_nxt   = tx_r;
    upd_nxt  = upd_r;
    rreq_nxt = rreq_r;
    rd       = '0;
    unique case (item.cmd)
      CMD_RX: begin
        if (item.bus_byte == cfg.start_read_code) begin
          ptr_nxt   = cfg.start_read_code;
          await_nxt = 1'b1;
        end else if (item.bus_byte == cfg.reset_code) begin
          rreq_nxt  = 1'b1;
          upd_nxt   = 1'b1;
          await_nxt = 1'b1;
        end else if (await_r) begin
          ptr_nxt   = item.bus_byte;
          await_nxt = 1'b0;
        end else begin
          if (ptr_r == cfg.x_reg_addr)      en_nxt[0] = item.bus_byte;
          else if (ptr_r == cfg.y_reg_addr) en_nxt[1] = item.bus_byte;
          else if (ptr_r == cfg.g_reg_addr) en_nxt[2] = item.bus_byte;
          await_nxt = 1'b1;
          upd_nxt   = 1'b1;
          ptr_nxt   = cfg.idle_pointer;
        end
      end
      CMD_READ: begin
        if (in_win) begin
          rd      = tx_rd;
          ptr_nxt = ptr_r + BYTE_W'(1);
        end else if (ptr_r == cfg.x_reg_addr) begin
          rd = en_r[0];
        end else if (ptr_r == cfg.y_reg_addr) begin
          rd = en_r[1];
        end else if (ptr_r == cfg.g_reg_addr) begin
          rd = en_r[2];
        end
      end
      CMD_FINISH: await_nxt = 1'b1;
      CMD_LOAD: begin
        for (int i = 0; i < TX_DEPTH; i++) begin
          if (item.buf_index == BUF_INDEX_W'(i)) tx_nxt[i] = item.bus_byte;
        end
      end
      CMD_CLEAR: begin
        upd_nxt  = 1'b0;
        rreq_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // Result shows the state after this beat
  assign res.read_byte     = rd;
  assign res.x_enable      = en_nxt[0];
  assign res.y_enable      = en_nxt[1];
  assign res.g_enable      = en_nxt[2];
  assign res.updated       = upd_nxt;
  assign res.reset_request = rreq_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= IDLE_POINTER_RST;
      await_r <= 1'b1;
      en_r    <= '{default: '0};
      tx_r    <= '{default: '0};
      upd_r   <= 1'b0;
      rreq_r  <= 1'b0;
    end else if (accept) begin
      ptr_r   <= ptr_nxt;
      await_r <= await_nxt;
      en_r    <= en_nxt;
      tx_r    <= tx_nxt;
      upd_r   <= upd_nxt;
      rreq_r  <= rreq_nxt;
    end
  end

endmodule

// ===== src/i2ctrm_outreg.sv =====
// Result register for the output channel; stalls the input only when full and held.
// Depends on i2ctrm_pkg.
`timescale 1ns / 1ps

module i2ctrm_outreg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  i2ctrm_pkg::out_t  res,
  output logic              out_valid,
  input  logic              out_stall,
  output i2ctrm_pkg::out_t  out_data,
  output logic              accept
);
  import i2ctrm_pkg::*;

  logic valid_r, valid_nxt;
  out_t data_r,  data_nxt;

  assign in_stall = valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (accept) begin
      valid_nxt = 1'b1;
      data_nxt  = res;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/i2c_target_register_map.sv =====
// A result beat is valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; the single result register is the only limit,
// and input is stalled only while that register is full and the output is stalled.
// Reset (rst_n low, synchronous): configuration to defaults, pointer 255, awaiting a
// pointer, enables, flags and transmit buffer zero, output empty.
// Top level of the I2C target register map; uses i2ctrm_pkg and the i2ctrm_* modules.
`timescale 1ns / 1ps

module i2c_target_register_map #(
  parameter int BUFFER_BYTES = i2ctrm_pkg::BUFFER_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  i2ctrm_pkg::in_t                    in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output i2ctrm_pkg::out_t                   out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [i2ctrm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [i2ctrm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [i2ctrm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                               pready
);
  import i2ctrm_pkg::*;

  cfg_t cfg;
  out_t res;
  logic accept;

  i2ctrm_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2ctrm_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .cfg    (cfg),
    .res    (res)
  );

  i2ctrm_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .accept    (accept)
  );

endmodule

// ===== src/i2ctrm_checker.sv =====
// Port-level assertions for the I2C target register map, bound to the top level.
// Depends on i2ctrm_pkg and i2c_target_register_map.
`timescale 1ns / 1ps

module i2ctrm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input i2ctrm_pkg::in_t   in_data,
  input logic              out_valid,
  input logic              out_stall,
  input i2ctrm_pkg::out_t  out_data
);
  import i2ctrm_pkg::*;

  // Input only backs up when a result is waiting and held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // Every accepted beat shows up in the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted beat produced no result");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.cmd == CMD_CLEAR) |=>
      (!out_data.updated && !out_data.reset_request))
    else $error("clear left a flag set");

  // Reset request is always raised together with updated
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.reset_request) |-> out_data.updated)
    else $error("reset request without updated flag");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("held result beat changed");

endmodule

bind i2c_target_register_map i2ctrm_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
